// ===== rtl/tmsd_pkg.sv =====
// Shared types, codes and constants for the thermostat motor direction soft-start block.
// No dependencies; every other file imports this package.
`default_nettype none

package tmsd_pkg;

	// Fixed field widths
	localparam int ADC_BITS  = 12;
	localparam int CMD_W     = 3;
	localparam int DIR_W     = 2;
	localparam int DUTY_W    = 8;
	localparam int MODE_W    = 2;
	localparam int TEMP_W    = 6;
	localparam int THR_W     = 6;
	localparam int PRE_W     = 16;
	localparam int STEP_W    = 10;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

	// Temperature mapping: clamp, then 15 + floor((1965 - x) / 11).
	// The divide by 11 is a multiply by 373 and a 12-bit shift, exact for 0..495.
	localparam int RAW_W     = 11;
	localparam int DIFF_W    = 9;
	localparam int RECIP_W   = 9;
	localparam int PROD_W    = DIFF_W + RECIP_W;
	localparam int RECIP_SH  = 12;
	localparam logic [RAW_W-1:0]   RAW_COLD_END = 11'd1965;
	localparam logic [RAW_W-1:0]   RAW_HOT_END  = 11'd1470;
	localparam logic [RECIP_W-1:0] RECIP_11     = 9'd373;
	localparam logic [TEMP_W-1:0]  DEG_LOW      = 6'd15;

	// Register reset values
	localparam logic [THR_W-1:0]  COLD_RST = 6'd20;
	localparam logic [THR_W-1:0]  HOT_RST  = 6'd50;
	localparam logic [PRE_W-1:0]  PRE_RST  = 16'd2000;
	localparam logic [STEP_W-1:0] STEP_RST = 10'd58;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLD = 2'd0,
		CFG_HOT  = 2'd1,
		CFG_PRE  = 2'd2,
		CFG_STEP = 2'd3
	} cfg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 3'd0,
		CMD_TICK   = 3'd1,
		CMD_ON     = 3'd2,
		CMD_OFF    = 3'd3,
		CMD_COLD   = 3'd4,
		CMD_HOT    = 3'd5,
		CMD_GET    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PRE  = 2'd1,
		PH_RAMP = 2'd2
	} phase_t;

	// Direction and mode share encodings: off/stopped, clockwise/cold, ccw/hot
	localparam logic [DIR_W-1:0]  DIR_OFF    = 2'd0;
	localparam logic [DIR_W-1:0]  DIR_CW     = 2'd1;
	localparam logic [DIR_W-1:0]  DIR_CCW    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COLD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOT   = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [ADC_BITS-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic [DIR_W-1:0]  direction;
		logic [DUTY_W-1:0] duty;
		logic [MODE_W-1:0] mode;
		logic              busy_res;
		logic [TEMP_W-1:0] temperature;
		logic              temp_valid;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0]  cold_threshold;
		logic [THR_W-1:0]  hot_threshold;
		logic [PRE_W-1:0]  pre_ramp_ticks;
		logic [STEP_W-1:0] step_ticks;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ===== rtl/thermostat_motor_direction_softstart_core.sv =====
// Top level of the thermostat motor drive with direction control and soft start.
// Depends on tmsd_pkg, tmsd_cfg_regs, tmsd_ctrl (which uses tmsd_temp_map).
//
//   channel | signals                          | role
//   --------+----------------------------------+-------------------------------------
//   in      | in_valid, in_stall, in_data      | samples, ticks and host commands
//   out     | out_valid, out_stall, out_data   | one status result per transaction
//   cfg     | cfg_we, cfg_idx, cfg_wdata       | thresholds, pre-delay, step interval
//
// Each transaction is captured in an input register, runs through the combinational
// controller and lands in the result register; one transaction per cycle is sustained
// while the output is not stalled, limited by the single controller state update.
// Reset clears the pipeline valid flags, the drive state and loads register defaults.
// A stalled result holds the result register; the input register keeps taking a
// transaction while it is empty, and stalls only when it is full and cannot advance.
`default_nettype none

module thermostat_motor_direction_softstart_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire tmsd_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tmsd_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_we,
	input  wire logic [tmsd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [tmsd_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import tmsd_pkg::*;

	cfg_regs_t cfg;
	in_item_t  item_s1;
	logic      vld_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      vld_s2;
	logic      adv;
	logic      fire_s1;

	tmsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Result stage can take a new transaction when empty or being drained
	assign adv      = !vld_s2 || !out_stall;
	assign fire_s1  = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Advance drive state only when the transaction moves into the result stage
	tmsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (fire_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

endmodule

`default_nettype wire

// ===== rtl/tmsd_cfg_regs.sv =====
// Configuration register file: thresholds and ramp timing.
// Depends on tmsd_pkg.
`default_nettype none

module tmsd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tmsd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [tmsd_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output tmsd_pkg::cfg_regs_t                 cfg
);
	import tmsd_pkg::*;

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cold_threshold <= COLD_RST;
			cfg_q.hot_threshold  <= HOT_RST;
			cfg_q.pre_ramp_ticks <= PRE_RST;
			cfg_q.step_ticks     <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_COLD: cfg_q.cold_threshold <= cfg_wdata[THR_W-1:0];
				CFG_HOT:  cfg_q.hot_threshold  <= cfg_wdata[THR_W-1:0];
				CFG_PRE:  cfg_q.pre_ramp_ticks <= cfg_wdata[PRE_W-1:0];
				CFG_STEP: cfg_q.step_ticks     <= cfg_wdata[STEP_W-1:0];
				default:  cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tmsd_temp_map.sv =====
// Raw converter reading to whole degrees (15..60): clamp and scale.
// Depends on tmsd_pkg.
`default_nettype none

module tmsd_temp_map (
	input  wire logic [tmsd_pkg::ADC_BITS-1:0] adc_sample,
	output logic      [tmsd_pkg::TEMP_W-1:0]   temperature
);
	import tmsd_pkg::*;

	logic [RAW_W-1:0]  x_clamp;
	logic [DIFF_W-1:0] diff;
	logic [PROD_W-1:0] prod;

	always_comb begin
		priority if (adc_sample < ADC_BITS'(RAW_HOT_END)) begin
			x_clamp = RAW_HOT_END;
		end else if (adc_sample > ADC_BITS'(RAW_COLD_END)) begin
			x_clamp = RAW_COLD_END;
		end else begin
			x_clamp = adc_sample[RAW_W-1:0];
		end
	end

	assign diff = DIFF_W'(RAW_COLD_END - x_clamp);
	// floor(diff / 11) through the reciprocal
	assign prod = PROD_W'(diff) * PROD_W'(RECIP_11);
	assign temperature = DEG_LOW + prod[RECIP_SH +: TEMP_W];

endmodule

`default_nettype wire

// ===== rtl/tmsd_ctrl.sv =====
// Drive controller: mode, direction, soft-start phase, tick counter and duty.
// Depends on tmsd_pkg and tmsd_temp_map.
`default_nettype none

module tmsd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 upd,
	input  wire tmsd_pkg::in_item_t   item,
	input  wire tmsd_pkg::cfg_regs_t  cfg,
	output tmsd_pkg::out_item_t       res
);
	import tmsd_pkg::*;

	logic [MODE_W-1:0] mode_q, mode_d;
	logic [DIR_W-1:0]  dir_q, dir_d;
	logic [DUTY_W-1:0] duty_q, duty_d;
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;

	logic [TEMP_W-1:0] temp;
	logic [TICK_W-1:0] tick_inc;
	logic [STEP_W-1:0] step_eff;
	phase_t            start_phase;

	tmsd_temp_map u_map (
		.adc_sample  (item.adc_sample),
		.temperature (temp)
	);

	assign tick_inc    = tick_q + TICK_W'(1);
	assign step_eff    = (cfg.step_ticks == '0) ? STEP_W'(1) : cfg.step_ticks;
	assign start_phase = (cfg.pre_ramp_ticks == '0) ? PH_RAMP : PH_PRE;

	// Next state
	always_comb begin
		mode_d  = mode_q;
		dir_d   = dir_q;
		duty_d  = duty_q;
		phase_d = phase_q;
		tick_d  = tick_q;
		unique case (cmd_t'(item.cmd))
			CMD_SAMPLE: begin
				if (phase_q == PH_IDLE) begin
					priority if (temp < cfg.cold_threshold && mode_q != MODE_COLD) begin
						mode_d  = MODE_COLD;
						dir_d   = DIR_CW;
						duty_d  = '0;
						tick_d  = '0;
						phase_d = start_phase;
					end else if (temp > cfg.hot_threshold && mode_q != MODE_HOT) begin
						mode_d  = MODE_HOT;
						dir_d   = DIR_CCW;
						duty_d  = '0;
						tick_d  = '0;
						phase_d = start_phase;
					end else if (temp >= cfg.cold_threshold && temp <= cfg.hot_threshold
							&& mode_q != MODE_STOP) begin
						mode_d  = MODE_STOP;
						dir_d   = DIR_OFF;
						duty_d  = '0;
						tick_d  = '0;
					end else begin
						mode_d = mode_q;
					end
				end
			end
			CMD_TICK: begin
				unique case (phase_q)
					PH_PRE: begin
						tick_d = tick_inc;
						if (tick_inc >= cfg.pre_ramp_ticks) begin
							phase_d = PH_RAMP;
							tick_d  = '0;
							duty_d  = '0;
						end
					end
					PH_RAMP: begin
						tick_d = tick_inc;
						if (tick_inc >= TICK_W'(step_eff)) begin
							tick_d = '0;
							if (duty_q < DUTY_MAX) begin
								duty_d = duty_q + DUTY_W'(1);
							end else begin
								phase_d = PH_IDLE;
							end
						end
					end
					default: tick_d = tick_q;
				endcase
			end
			CMD_ON, CMD_OFF: begin
				if (cmd_t'(item.cmd) == CMD_ON) begin
					mode_d = MODE_STOP;
				end
				dir_d   = DIR_OFF;
				duty_d  = '0;
				tick_d  = '0;
				phase_d = PH_IDLE;
			end
			CMD_COLD, CMD_HOT: begin
				mode_d  = (cmd_t'(item.cmd) == CMD_COLD) ? MODE_COLD : MODE_HOT;
				dir_d   = (cmd_t'(item.cmd) == CMD_COLD) ? DIR_CW : DIR_CCW;
				duty_d  = '0;
				tick_d  = '0;
				phase_d = start_phase;
			end
			default: mode_d = mode_q;
		endcase
	end

	// Outputs: status after this transaction
	always_comb begin
		res.direction   = dir_d;
		res.duty        = duty_d;
		res.mode        = mode_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.temp_valid  = (cmd_t'(item.cmd) == CMD_GET);
		res.temperature = res.temp_valid ? temp : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STOP;
			dir_q   <= DIR_OFF;
			duty_q  <= '0;
			phase_q <= PH_IDLE;
			tick_q  <= '0;
		end else if (upd) begin
			mode_q  <= mode_d;
			dir_q   <= dir_d;
			duty_q  <= duty_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tmsd_drive_monitor.sv =====
// Monitor and scoreboard for the thermostat motor drive: predicts every status result
// from the input and configuration traffic and checks the output channel against it.
// Depends on tmsd_pkg.
module tmsd_drive_monitor
	import tmsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	output int                   errors,
	output int                   outstanding,
	output int                   results_seen
);

	localparam int DEG_SPAN = 45;
	localparam int RAW_SPAN = 495;

	cfg_regs_t          regs;
	logic [MODE_W-1:0]  mode_q;
	logic [DIR_W-1:0]   dir_q;
	logic [DUTY_W-1:0]  duty_q;
	phase_t             phase_q;
	logic [TICK_W-1:0]  ticks_q;
	out_item_t          due_status[$];

	initial begin
		errors = 0;
		outstanding = 0;
		results_seen = 0;
	end

	function automatic logic [TEMP_W-1:0] degrees(logic [ADC_BITS-1:0] raw);
		int x;
		x = int'(raw);
		if (x < int'(RAW_HOT_END)) x = int'(RAW_HOT_END);
		if (x > int'(RAW_COLD_END)) x = int'(RAW_COLD_END);
		return TEMP_W'(int'(DEG_LOW) + ((int'(RAW_COLD_END) - x) * DEG_SPAN) / RAW_SPAN);
	endfunction

	function automatic void halt();
		dir_q = DIR_OFF;
		duty_q = '0;
		phase_q = PH_IDLE;
		ticks_q = '0;
	endfunction

	function automatic void launch(logic [DIR_W-1:0] d, logic [MODE_W-1:0] m);
		halt();
		dir_q = d;
		mode_q = m;
		phase_q = (regs.pre_ramp_ticks == '0) ? PH_RAMP : PH_PRE;
	endfunction

	function automatic void count_tick();
		int interval;
		interval = (regs.step_ticks == '0) ? 1 : int'(regs.step_ticks);
		if (phase_q == PH_PRE) begin
			ticks_q = ticks_q + 1'b1;
			if (ticks_q >= regs.pre_ramp_ticks) begin
				phase_q = PH_RAMP;
				ticks_q = '0;
				duty_q = '0;
			end
		end else if (phase_q == PH_RAMP) begin
			ticks_q = ticks_q + 1'b1;
			if (int'(ticks_q) >= interval) begin
				ticks_q = '0;
				if (duty_q < DUTY_MAX) duty_q = duty_q + 1'b1;
				else phase_q = PH_IDLE;
			end
		end
	endfunction

	function automatic void judge_sample(logic [ADC_BITS-1:0] raw);
		int t;
		int cold;
		int hot;
		if (phase_q != PH_IDLE) return;
		t = int'(degrees(raw));
		cold = int'(regs.cold_threshold);
		hot = int'(regs.hot_threshold);
		if (t < cold && mode_q != MODE_COLD) begin
			launch(DIR_CW, MODE_COLD);
		end else if (t > hot && mode_q != MODE_HOT) begin
			launch(DIR_CCW, MODE_HOT);
		end else if (t >= cold && t <= hot && mode_q != MODE_STOP) begin
			halt();
			mode_q = MODE_STOP;
		end
	endfunction

	function automatic out_item_t drive_status_after(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.cmd)
			CMD_SAMPLE: judge_sample(it.adc_sample);
			CMD_TICK:   count_tick();
			CMD_ON: begin
				halt();
				mode_q = MODE_STOP;
			end
			CMD_OFF:    halt();
			CMD_COLD:   launch(DIR_CW, MODE_COLD);
			CMD_HOT:    launch(DIR_CCW, MODE_HOT);
			CMD_GET: begin
				r.temperature = degrees(it.adc_sample);
				r.temp_valid = 1'b1;
			end
			default: ;
		endcase
		r.direction = dir_q;
		r.duty = duty_q;
		r.mode = mode_q;
		r.busy_res = (phase_q != PH_IDLE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs = '{COLD_RST, HOT_RST, PRE_RST, STEP_RST};
			mode_q = MODE_STOP;
			halt();
			due_status.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_COLD: regs.cold_threshold = cfg_wdata[THR_W-1:0];
					CFG_HOT:  regs.hot_threshold = cfg_wdata[THR_W-1:0];
					CFG_PRE:  regs.pre_ramp_ticks = cfg_wdata[PRE_W-1:0];
					CFG_STEP: regs.step_ticks = cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) due_status.push_back(drive_status_after(in_data));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_status.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected status result: %p", out_data);
				end else begin
					want = due_status.pop_front();
					if (out_data.direction !== want.direction || out_data.duty !== want.duty ||
						out_data.mode !== want.mode || out_data.busy_res !== want.busy_res ||
						out_data.temperature !== want.temperature ||
						out_data.temp_valid !== want.temp_valid) begin
						errors++;
						if (errors <= 10) begin
							$display("status mismatch at result %0d (expected / actual):",
								results_seen);
							$display("  dir %0d/%0d duty %0d/%0d mode %0d/%0d busy %0b/%0b",
								want.direction, out_data.direction, want.duty, out_data.duty,
								want.mode, out_data.mode, want.busy_res, out_data.busy_res);
							$display("  temp %0d/%0d temp_valid %0b/%0b",
								want.temperature, out_data.temperature,
								want.temp_valid, out_data.temp_valid);
						end
					end
				end
			end
		end
		outstanding = due_status.size();
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the thermostat motor drive: directed and random command traffic
// under several register settings, with random input gaps and output stalls.
// Depends on tmsd_pkg, tmsd_drive_monitor and the thermostat_motor_direction_softstart_core RTL.
module tb;
	import tmsd_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	int errors;
	int outstanding;
	int results_seen;

	// Percent chances per cycle of an input gap and of an output stall
	int idle_pct = 21;
	int stall_pct = 21;
	int items_sent = 0;
	int settings_run = 0;

	always #10 clk = ~clk;

	thermostat_motor_direction_softstart_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	tmsd_drive_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.errors       (errors),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	// Stall the result channel at random, independent of the input side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offer one transaction, after an optional random gap, and hold it until accepted.
	// Called at a rising edge; returns at the edge that accepted it, valid still high.
	task automatic issue(logic [CMD_W-1:0] op, logic [ADC_BITS-1:0] raw);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{cmd: op, adc_sample: raw};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Drop valid and wait for every predicted result to come out; ends on a rising edge.
	// Every transaction yields a result, so an empty scoreboard means an idle block.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Write all four registers back to back while the block is idle
	task automatic load_regs(int cold, int hot, int pre, int step);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= CFG_COLD;
		cfg_wdata <= CFG_DAT_W'(cold);
		@(posedge clk);
		cfg_idx <= CFG_HOT;
		cfg_wdata <= CFG_DAT_W'(hot);
		@(posedge clk);
		cfg_idx <= CFG_PRE;
		cfg_wdata <= CFG_DAT_W'(pre);
		@(posedge clk);
		cfg_idx <= CFG_STEP;
		cfg_wdata <= CFG_DAT_W'(step);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Half the readings span the whole converter range, half sit around the mapped band
	function automatic logic [ADC_BITS-1:0] pick_raw();
		if ($urandom_range(1) == 1) return ADC_BITS'($urandom_range(4095));
		return ADC_BITS'($urandom_range(1440, 2000));
	endfunction

	// Mostly drive episodes: a start followed by a run of ticks with a few samples and
	// queries mixed in, cut short where the budget runs out. The rest is noise of
	// any command code, which also aborts ramps midway.
	task automatic random_traffic(int budget);
		int stop_at;
		int len;
		int roll;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 65) begin
				case ($urandom_range(2))
					0: issue(CMD_COLD, pick_raw());
					1: issue(CMD_HOT, pick_raw());
					default: issue(CMD_SAMPLE, pick_raw());
				endcase
				len = ($urandom_range(3) == 0) ? $urandom_range(200, 340) : $urandom_range(1, 30);
				if (len > stop_at - items_sent) len = stop_at - items_sent;
				repeat (len) begin
					roll = $urandom_range(99);
					if (roll < 80) issue(CMD_TICK, pick_raw());
					else if (roll < 90) issue(CMD_SAMPLE, pick_raw());
					else issue(CMD_GET, pick_raw());
				end
			end else begin
				repeat ($urandom_range(1, 8)) issue(CMD_W'($urandom_range(7)), pick_raw());
			end
		end
	endtask

	initial begin
		// Hold reset, then release it at a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: mapping extremes and clamp edges, then every command
		issue(CMD_GET, 12'd0);
		issue(CMD_GET, 12'hFFF);
		issue(CMD_GET, 12'd1470);
		issue(CMD_GET, 12'd1965);
		issue(CMD_GET, 12'd1469);
		issue(CMD_GET, 12'd1966);
		issue(CMD_GET, 12'd1717);
		issue(CMD_TICK, 12'd0);          // tick while idle does nothing
		issue(CMD_SAMPLE, 12'd1717);     // in band, already stopped
		issue(CMD_SAMPLE, 12'hFFF);      // coldest reading starts clockwise drive
		issue(CMD_SAMPLE, 12'd0);        // ignored while the start is in progress
		issue(CMD_TICK, 12'd0);
		issue(CMD_HOT, 12'd0);           // restart in the other direction
		issue(CMD_COLD, 12'd0);
		issue(CMD_COLD, 12'd0);          // restart even when the mode matches
		issue(CMD_OFF, 12'd0);           // stop but keep cold mode
		issue(CMD_SAMPLE, 12'd1717);     // in band with cold mode: stop
		issue(CMD_SAMPLE, 12'd0);        // hottest reading starts counter-clockwise
		issue(CMD_GET, 12'd2000);        // query leaves the pre-delay running
		issue(CMD_ON, 12'hFFF);
		issue(CMD_W'(7), 12'hFFF);       // unused code only reports status

		// Zero pre-delay and zero step interval: ramp starts at once, one tick per step.
		// Walk the whole ramp: 255 increments, one more step at full duty ends it,
		// then one tick while idle.
		load_regs(20, 50, 0, 0);
		issue(CMD_COLD, 12'd0);
		repeat (257) issue(CMD_TICK, 12'd0);
		issue(CMD_GET, 12'd1470);
		random_traffic(70);

		// Widest thresholds: only commands can start a drive
		load_regs(0, 63, 3, 1);
		random_traffic(70);

		// Crossed thresholds
		load_regs(50, 20, 2, 2);
		random_traffic(70);

		// Largest pre-delay and step interval: the drive never gets past its pre-delay
		load_regs(63, 0, 65535, 1023);
		random_traffic(40);

		// Run a stretch with no input gaps and no output stalls at all
		load_regs(35, 40, 1, 1);
		idle_pct = 0;
		stall_pct = 0;
		random_traffic(110);
		idle_pct = 21;
		stall_pct = 21;

		load_regs(15, 60, 0, 3);
		random_traffic(60);

		// Wait for the last results, then let the pipeline settle
		drain();
		repeat (4) @(posedge clk);

		$display("Sent %0d transactions under %0d register settings plus reset defaults,",
			items_sent, settings_run);
		$display("and checked %0d status results.", results_seen);
		if (errors == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#4000000;
		$display("Timeout with %0d results still outstanding", outstanding);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
